>>> hw/rtl/assert_macros.svh
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/isar_pkg.sv
// Package with types and constants for the interval set block.
`timescale 1ns / 1ps
package isar_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int POS_WIDTH   = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [POS_WIDTH-1:0] range_start;
        logic [POS_WIDTH-1:0] range_length;
        logic [3:0]           read_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [4:0]           entry_count;
        logic                 read_valid;
        logic [POS_WIDTH-1:0] read_start;
        logic [POS_WIDTH-1:0] read_length;
    } rsp_t;

    // entry as stored: start and exclusive end, one bit wider
    typedef struct packed {
        logic [POS_WIDTH:0] s;
        logic [POS_WIDTH:0] e;
    } ent_t;

    // memory port request from sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        ent_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;
endpackage

>>> hw/rtl/isar_mem.sv
// Entry table memory, one write and one registered read port.
`timescale 1ns / 1ps
module isar_mem (
    input  logic              clk,
    input  isar_pkg::mem_req_t req,
    output isar_pkg::ent_t     rdata
);
    import isar_pkg::*;

    ent_t mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

>>> hw/rtl/isar_seq.sv
// Sequencer: streams the table once per add or remove item, rebuilding it in the other bank.
`timescale 1ns / 1ps
module isar_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  isar_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output isar_pkg::rsp_t    rsp,
    output isar_pkg::mem_req_t req_a,
    output isar_pkg::mem_req_t req_b,
    input  isar_pkg::ent_t     rd_a,
    input  isar_pkg::ent_t     rd_b
);
    import isar_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 bank_reg, bank_next;      // bank holding live table
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     rptr_reg, rptr_next;      // next read address
    logic [CNT_W-1:0]     wcnt_reg, wcnt_next;      // entries written to new bank
    logic                 vld_reg, vld_next;        // read data valid this cycle
    logic [1:0]           kind_reg, kind_next;
    logic [POS_WIDTH:0]   s_reg, s_next, e_reg, e_next;
    logic [3:0]           ridx_reg, ridx_next;
    logic                 pend_reg, pend_next;      // add range not yet emitted
    logic [1:0]           stat_reg, stat_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    ent_t                 cur;
    ent_t                 w0, w1;
    logic                 nw0, nw1;
    logic [POS_WIDTH:0]   in_s, in_e;
    logic                 rd_live;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;
    assign cur  = bank_reg ? rd_b : rd_a;
    assign in_s = {1'b0, cmd.range_start};
    assign in_e = {1'b0, cmd.range_start} + {1'b0, cmd.range_length};

    always_comb
    begin
        w0 = '0;
        w1 = '0;
        nw0 = 1'b0;
        nw1 = 1'b0;
        pend_next = pend_reg;
        s_next = s_reg;
        e_next = e_reg;
        if (state_reg == S_SCAN)
        begin
            if (vld_reg)
            begin
                if (kind_reg == KIND_ADD)
                begin
                    if (cur.e < s_reg)
                    begin
                        w0 = cur; nw0 = 1'b1;
                    end
                    else if (cur.s > e_reg)
                    begin
                        if (pend_reg)
                        begin
                            w0 = '{s: s_reg, e: e_reg}; nw0 = 1'b1;
                            pend_next = 1'b0;
                            w1 = cur; nw1 = 1'b1;
                        end
                        else
                        begin
                            w0 = cur; nw0 = 1'b1;
                        end
                    end
                    else
                    begin
                        if (cur.s < s_reg) s_next = cur.s;
                        if (cur.e > e_reg) e_next = cur.e;
                    end
                end
                else
                begin
                    if (cur.e <= s_reg || cur.s >= e_reg)
                    begin
                        w0 = cur; nw0 = 1'b1;
                    end
                    else
                    begin
                        if (cur.s < s_reg)
                        begin
                            w0 = '{s: cur.s, e: s_reg}; nw0 = 1'b1;
                        end
                        if (cur.e > e_reg)
                        begin
                            if (nw0)
                            begin
                                w1 = '{s: e_reg, e: cur.e}; nw1 = 1'b1;
                            end
                            else
                            begin
                                w0 = '{s: e_reg, e: cur.e}; nw0 = 1'b1;
                            end
                        end
                    end
                end
            end
            else if (pend_reg && rptr_reg == held_reg)
            begin
                w0 = '{s: s_reg, e: e_reg}; nw0 = 1'b1;
                pend_next = 1'b0;
            end
        end
    end

    // second entry of a split or a flushed add goes out next cycle
    logic   hold_reg, hold_next;
    ent_t   hent_reg, hent_next;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        held_next  = held_reg;
        rptr_next  = rptr_reg;
        wcnt_next  = wcnt_reg;
        vld_next   = 1'b0;
        kind_next  = kind_reg;
        ridx_next  = ridx_reg;
        stat_next  = stat_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        hold_next  = 1'b0;
        hent_next  = hent_reg;
        req_a = '0;
        req_b = '0;
        rd_live = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = cmd.kind;
                    ridx_next = cmd.read_index;
                    rptr_next = '0;
                    wcnt_next = '0;
                    stat_next = ST_DONE;
                    state_next = S_SCAN;
                    if ((cmd.kind == KIND_ADD || cmd.kind == KIND_REMOVE) &&
                        in_e[POS_WIDTH] && in_e[POS_WIDTH-1:0] != '0)
                    begin
                        stat_next = ST_RANGE;
                        kind_next = KIND_NONE;
                    end
                    else if ((cmd.kind == KIND_ADD || cmd.kind == KIND_REMOVE) &&
                             cmd.range_length == '0)
                    begin
                        kind_next = KIND_NONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (kind_reg == KIND_ADD || kind_reg == KIND_REMOVE)
                begin
                    // no read while a second entry is queued, so no entry arrives unhandled
                    if (rptr_reg < held_reg && !nw1)
                    begin
                        rd_live = 1'b1;
                        rptr_next = rptr_reg + 1'b1;
                        vld_next = 1'b1;
                    end
                    if (hold_reg)
                    begin
                        if (wcnt_reg < CNT_W'(MAX_ENTRIES))
                        begin
                            if (bank_reg) req_a.we = 1'b1; else req_b.we = 1'b1;
                            req_a.waddr = wcnt_reg[IDX_W-1:0];
                            req_b.waddr = wcnt_reg[IDX_W-1:0];
                            req_a.wdata = hent_reg;
                            req_b.wdata = hent_reg;
                        end
                        else
                        begin
                            stat_next = ST_FULL;
                        end
                        wcnt_next = wcnt_reg + 1'b1;
                    end
                    else if (nw0)
                    begin
                        if (wcnt_reg < CNT_W'(MAX_ENTRIES))
                        begin
                            if (bank_reg) req_a.we = 1'b1; else req_b.we = 1'b1;
                            req_a.waddr = wcnt_reg[IDX_W-1:0];
                            req_b.waddr = wcnt_reg[IDX_W-1:0];
                            req_a.wdata = w0;
                            req_b.wdata = w0;
                        end
                        else
                        begin
                            stat_next = ST_FULL;
                        end
                        wcnt_next = wcnt_reg + 1'b1;
                        if (nw1)
                        begin
                            hold_next = 1'b1;
                            hent_next = w1;
                        end
                    end
                    if (!rd_live && !vld_reg && !hold_reg && !nw0 && !pend_next)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (kind_reg == KIND_READ && {1'b0, ridx_reg} < held_reg)
                    begin
                        rd_live = 1'b1;
                    end
                    if (vld_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (rd_live)
                    begin
                        vld_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                done_next = 1'b1;
                rsp_next = '0;
                rsp_next.status = stat_reg;
                if ((kind_reg == KIND_ADD || kind_reg == KIND_REMOVE) &&
                    stat_reg == ST_DONE)
                begin
                    if (kind_reg == KIND_ADD && (e_reg - s_reg) >= {1'b1, {POS_WIDTH{1'b0}}})
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        bank_next = ~bank_reg;
                        held_next = wcnt_reg;
                    end
                end
                else if (kind_reg == KIND_ADD && stat_reg == ST_FULL)
                begin
                    rsp_next.status = ((e_reg - s_reg) >= {1'b1, {POS_WIDTH{1'b0}}})
                                      ? ST_RANGE : ST_FULL;
                end
                rsp_next.entry_count = 5'(bank_next == bank_reg ? held_reg : wcnt_reg);
                if (kind_reg == KIND_READ && {1'b0, ridx_reg} < held_reg)
                begin
                    rsp_next.read_valid  = 1'b1;
                    rsp_next.read_start  = cur.s[POS_WIDTH-1:0];
                    rsp_next.read_length = POS_WIDTH'(cur.e - cur.s);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (kind_reg == KIND_READ)
        begin
            req_a.raddr = ridx_reg[IDX_W-1:0];
            req_b.raddr = ridx_reg[IDX_W-1:0];
        end
        else
        begin
            req_a.raddr = rptr_reg[IDX_W-1:0];
            req_b.raddr = rptr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            held_reg  <= '0;
            rptr_reg  <= '0;
            wcnt_reg  <= '0;
            vld_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            hold_reg  <= 1'b0;
            stat_reg  <= ST_DONE;
            kind_reg  <= KIND_READ;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            held_reg  <= held_next;
            rptr_reg  <= rptr_next;
            wcnt_reg  <= wcnt_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
            hold_reg  <= hold_next;
            stat_reg  <= stat_next;
            kind_reg  <= kind_next;
            if (state_reg == S_IDLE && start)
            begin
                pend_reg <= (cmd.kind == KIND_ADD);
            end
            else
            begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        rsp_reg  <= rsp_next;
        hent_reg <= hent_next;
        if (state_reg == S_IDLE && start)
        begin
            s_reg <= in_s;
            e_reg <= in_e;
        end
        else
        begin
            s_reg <= s_next;
            e_reg <= e_next;
        end
    end
endmodule

>>> hw/rtl/interval_set_add_remove_top.sv
// Top level of the interval set block.
`timescale 1ns / 1ps
// Raise start with an item while busy is low; exactly one result appears for one
// cycle with done high and cannot be held off, and busy is low in that cycle. A read
// first fetches the indexed entry from the live memory bank; an index past the held
// entries, or a rejected, zero-length or unused item, goes straight to its result. An
// add or remove streams every held entry from the live memory bank into the other
// bank, so it lasts longer the more entries are held. The live bank has a single
// read port, so its entries are read one at a time.
module interval_set_add_remove_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  isar_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done,
    output isar_pkg::rsp_t   rsp
);
    import isar_pkg::*;

    mem_req_t req_a, req_b;
    ent_t     rd_a, rd_b;

    isar_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp),
        .req_a (req_a),
        .req_b (req_b),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

    isar_mem u_mem_a (
        .clk   (clk),
        .req   (req_a),
        .rdata (rd_a)
    );

    isar_mem u_mem_b (
        .clk   (clk),
        .req   (req_b),
        .rdata (rd_b)
    );
endmodule

>>> hw/rtl/isar_checker.sv
// Port checker for the interval set block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module isar_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input isar_pkg::rsp_t rsp
);
    import isar_pkg::*;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ASSERT_IMPL(a_count_max, clk, rst_n, done, rsp.entry_count <= 5'(MAX_ENTRIES))
    `ASSERT_IMPL(a_read_zero, clk, rst_n, done && !rsp.read_valid,
                 rsp.read_start == '0 && rsp.read_length == '0)
endmodule

bind interval_set_add_remove_top isar_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
